// ----- sv/scl_pkg.sv -----
package scl_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = 8;
    localparam int TAP_IDX_W    = 4;
    localparam int CNT_W        = 5;
    localparam int PHASE_W      = 4;
    localparam int MAX_STRIDE   = 16;
    localparam int LEAK_SHIFT   = 2 * FRAC_BITS;
    localparam int SAMPLE_MAX   = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SAMPLE_MIN   = -(1 << (SAMPLE_BITS - 1));
    localparam int MAX_TAPS_DEF = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAP_COUNT = 2'd0,
        CFG_STRIDE    = 2'd1,
        CFG_BIAS      = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_LOAD   = 1'b1
    } cmd_t;

    localparam logic [CNT_W-1:0] TAP_COUNT_RST = 5'd16;
    localparam logic [CNT_W-1:0] STRIDE_RST    = 5'd2;

    typedef struct packed {
        logic                          command;
        logic [TAP_IDX_W-1:0]          tap_index;
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          last;
    } s_word_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] result;
        logic                          has_value;
        logic                          row_end;
        logic                          status;
    } m_word_t;

    // Per-word flags carried down the pipeline
    typedef struct packed {
        logic valid;
        logic fired;
        logic last;
        logic short_row;
    } meta_t;

endpackage

// ----- sv/strided_conv1d_bias_leaky_relu_top.sv -----
// Strided 1-D convolution with bias and leaky ReLU (slope 26/256), Q8.8 in and out.
// Sample words stream in one per cycle while the output is not stalled; load words
// (command = 1) write one filter tap. A window is evaluated every stride samples once
// tap_count samples of the row have arrived; the sample word with last = 1 always yields
// a result word, with has_value = 0 when it completes no window and status = 1 when the
// row was shorter than the filter. Throughput is one word per cycle unless m_ready stalls
// the output. The products, a four-input adder stage and the final sum with bias each sit
// behind a register, and the activation with saturation feeds the output register. All
// stages advance together, so the pipeline holds while a result waits on m_ready.
// Configuration (tap_count, stride, bias) must only be written while no row is in flight.
module strided_conv1d_bias_leaky_relu_top #(
    parameter int MAX_TAPS = scl_pkg::MAX_TAPS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  scl_pkg::s_word_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output scl_pkg::m_word_t               m_data,
    input  logic                           cfg_we,
    input  logic [scl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import scl_pkg::*;

    localparam int FW   = $clog2(MAX_TAPS + 1);
    localparam int PW   = 2 * SAMPLE_BITS;
    localparam int NGRP = (MAX_TAPS + 3) / 4;
    localparam int GW   = PW + 2;
    localparam int AW   = PW + $clog2(MAX_TAPS) + 2;
    localparam int LW   = AW + 5;

    // Configuration registers
    logic [CNT_W-1:0]              tap_count_reg;
    logic [CNT_W-1:0]              stride_reg;
    logic signed [SAMPLE_BITS-1:0] bias_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= TAP_COUNT_RST;
            stride_reg    <= STRIDE_RST;
            bias_reg      <= '0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                CFG_TAP_COUNT: tap_count_reg <= cfg_wdata[CNT_W-1:0];
                CFG_STRIDE:    stride_reg    <= cfg_wdata[CNT_W-1:0];
                CFG_BIAS:      bias_reg      <= SAMPLE_BITS'(signed'(cfg_wdata));
                default: ;
            endcase
        end
    end

    // Pipeline advance: everything moves when the output slot is free or being taken
    logic adv;
    logic s_acc;
    logic is_sample;
    logic is_load;

    assign adv       = !m_valid || m_ready;
    assign s_ready   = adv;
    assign s_acc     = s_valid && s_ready;
    assign is_sample = s_acc && (cmd_t'(s_data.command) == CMD_SAMPLE);
    assign is_load   = s_acc && (cmd_t'(s_data.command) == CMD_LOAD);

    // Effective tap count and stride
    logic [FW-1:0]    t_eff;
    logic [CNT_W-1:0] s_eff;

    always_comb begin
        if (tap_count_reg == '0) begin
            t_eff = FW'(1);
        end else if (int'(tap_count_reg) > MAX_TAPS) begin
            t_eff = FW'(MAX_TAPS);
        end else begin
            t_eff = FW'(tap_count_reg);
        end
        if (stride_reg == '0) begin
            s_eff = CNT_W'(1);
        end else if (int'(stride_reg) > MAX_STRIDE) begin
            s_eff = CNT_W'(MAX_STRIDE);
        end else begin
            s_eff = stride_reg;
        end
    end

    // Row position tracking
    logic [FW-1:0]      fill_reg, fill_next, fill_inc;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PHASE_W:0]   phase_plus;
    logic               window_full;
    logic               fire;
    meta_t              meta1_next;

    always_comb begin
        fill_inc    = (fill_reg < t_eff) ? fill_reg + FW'(1) : fill_reg;
        window_full = (fill_inc >= t_eff);
        fire        = window_full && (phase_reg == '0);
        phase_plus  = {1'b0, phase_reg} + (PHASE_W+1)'(1);
        fill_next   = fill_reg;
        phase_next  = phase_reg;
        if (is_sample) begin
            if (s_data.last) begin
                fill_next  = '0;
                phase_next = '0;
            end else begin
                fill_next = fill_inc;
                if (window_full) begin
                    phase_next = (phase_plus >= s_eff) ? '0 : phase_plus[PHASE_W-1:0];
                end
            end
        end
        meta1_next.valid     = is_sample && (fire || s_data.last);
        meta1_next.fired     = fire;
        meta1_next.last      = s_data.last;
        meta1_next.short_row = s_data.last && !window_full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            phase_reg <= '0;
        end else begin
            fill_reg  <= fill_next;
            phase_reg <= phase_next;
        end
    end

    // Sample history and tap store
    logic signed [SAMPLE_BITS-1:0] win_reg [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] tap_reg [MAX_TAPS];

    always_ff @(posedge aclk) begin
        if (is_sample) begin
            win_reg[0] <= s_data.value;
            for (int k = 1; k < MAX_TAPS; k++) begin
                win_reg[k] <= win_reg[k-1];
            end
        end
        for (int i = 0; i < MAX_TAPS; i++) begin
            if (is_load && (32'(s_data.tap_index) == i)) begin
                tap_reg[i] <= s_data.value;
            end
        end
    end

    // Stage 1: flags and tap count of the word just taken
    meta_t         meta1_reg, meta2_reg, meta3_reg, meta4_reg;
    logic [FW-1:0] t1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta1_reg <= '0;
            meta2_reg <= '0;
            meta3_reg <= '0;
            meta4_reg <= '0;
        end else if (adv) begin
            meta1_reg <= meta1_next;
            meta2_reg <= meta1_reg;
            meta3_reg <= meta2_reg;
            meta4_reg <= meta3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_reg <= t_eff;
        end
    end

    // Stage 2: one product per tap, tap n against sample t-1-n
    logic signed [SAMPLE_BITS-1:0] sel [MAX_TAPS];
    logic signed [PW-1:0]          prod_next [MAX_TAPS];
    logic signed [PW-1:0]          prod_reg  [MAX_TAPS];

    always_comb begin
        for (int n = 0; n < MAX_TAPS; n++) begin
            sel[n] = '0;
            for (int k = 0; k < MAX_TAPS; k++) begin
                if (k + n + 1 == int'(t1_reg)) begin
                    sel[n] = win_reg[k];
                end
            end
            // signed product; unused taps contribute nothing
            if (int'(t1_reg) > n) begin
                prod_next[n] = PW'(sel[n]) * PW'(tap_reg[n]);
            end else begin
                prod_next[n] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
        end
    end

    // Stage 3: sums of four products
    logic signed [GW-1:0] grp_next [NGRP];
    logic signed [GW-1:0] grp_reg  [NGRP];

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_next[g] = '0;
            for (int j = 0; j < 4; j++) begin
                if (g * 4 + j < MAX_TAPS) begin
                    grp_next[g] = grp_next[g] + GW'(prod_reg[g*4+j]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            grp_reg <= grp_next;
        end
    end

    // Stage 4: window sum plus bias aligned to Q16.16
    logic signed [AW-1:0] acc_next, acc_reg;

    always_comb begin
        acc_next = AW'(bias_reg) <<< FRAC_BITS;
        for (int g = 0; g < NGRP; g++) begin
            acc_next = acc_next + AW'(grp_reg[g]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            acc_reg <= acc_next;
        end
    end

    // Output: leaky ReLU, floor to Q8.8, saturate
    logic signed [LW-1:0]          acc_ext;
    logic signed [LW-1:0]          leak;
    logic signed [LW-1:0]          scaled;
    logic signed [SAMPLE_BITS-1:0] act;
    m_word_t                       m_data_next;

    always_comb begin
        acc_ext = LW'(acc_reg);
        leak    = (acc_ext <<< 4) + (acc_ext <<< 3) + (acc_ext <<< 1);
        if (acc_reg > 0) begin
            scaled = acc_ext >>> FRAC_BITS;
        end else begin
            scaled = leak >>> LEAK_SHIFT;
        end
        if (scaled > LW'(SAMPLE_MAX)) begin
            act = SAMPLE_BITS'(SAMPLE_MAX);
        end else if (scaled < LW'(SAMPLE_MIN)) begin
            act = SAMPLE_BITS'(SAMPLE_MIN);
        end else begin
            act = scaled[SAMPLE_BITS-1:0];
        end
        m_data_next.result    = meta4_reg.fired ? act : '0;
        m_data_next.has_value = meta4_reg.fired;
        m_data_next.row_end   = meta4_reg.last;
        m_data_next.status    = meta4_reg.short_row;
    end

    logic    m_valid_reg;
    m_word_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= meta4_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- sv/scl_checker.sv -----
module scl_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input scl_pkg::s_word_t               s_data,
    input logic                           m_valid,
    input logic                           m_ready,
    input scl_pkg::m_word_t               m_data,
    input logic                           cfg_we,
    input logic [scl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [scl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import scl_pkg::*;

    // A held result word stays put until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // No result straight out of reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result word valid after reset");

    // An empty output slot never blocks the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // Short row flag comes only on a row end without a value
    a_short_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |-> m_data.row_end && !m_data.has_value)
        else $error("short row flag on wrong word");

    // A word without a window carries a zero result and ends a row
    a_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.has_value |-> m_data.result == '0 && m_data.row_end)
        else $error("valueless word malformed");

endmodule

bind strided_conv1d_bias_leaky_relu_top scl_checker u_scl_checker (.*);

// ----- test/conv1d_result_monitor.sv -----
module conv1d_result_monitor
    import scl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  s_word_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  m_word_t               m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    err_count,
    output int                    outstanding,
    output int                    samples_seen,
    output int                    loads_seen,
    output int                    results_seen,
    output int                    windows_seen,
    output int                    short_rows_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEAK_NUM = 26;

    // Shadow copy of the registers and the row state
    logic [CNT_W-1:0]              tap_count_q;
    logic [CNT_W-1:0]              stride_q;
    logic signed [SAMPLE_BITS-1:0] bias_q;
    logic signed [SAMPLE_BITS-1:0] row_samples [MAX_TAPS_DEF];
    logic signed [SAMPLE_BITS-1:0] tap_coeffs  [MAX_TAPS_DEF];
    int unsigned                   fill_count;
    int unsigned                   stride_phase;

    // Result words still owed by the block, oldest first
    m_word_t pending_outputs [$];

    int errs      = 0;
    int n_samples = 0;
    int n_loads   = 0;
    int n_results = 0;
    int n_windows = 0;
    int n_short   = 0;

    task automatic clear_row();
        foreach (row_samples[i]) row_samples[i] = '0;
        fill_count   = 0;
        stride_phase = 0;
    endtask

    // Q8.8 output of the current window: exact sum, bias, leaky ReLU, floor, saturate
    function automatic logic signed [SAMPLE_BITS-1:0] window_value(int unsigned n_taps);
        longint acc;
        longint r;
        acc = 0;
        for (int n = 0; n < n_taps; n++)
            acc += longint'(row_samples[n_taps-1-n]) * longint'(tap_coeffs[n]);
        acc += longint'(bias_q) * (longint'(1) << FRAC_BITS);
        if (acc > 0)
            r = acc >>> FRAC_BITS;
        else
            r = (acc * LEAK_NUM) >>> LEAK_SHIFT;
        if (r < SAMPLE_MIN)
            r = SAMPLE_MIN;
        if (r > SAMPLE_MAX)
            r = SAMPLE_MAX;
        return r[SAMPLE_BITS-1:0];
    endfunction

    // Advance the row by one accepted input word and queue any result it owes
    task automatic take_word(input s_word_t w);
        int unsigned n_taps;
        int unsigned n_stride;
        logic        fired;
        m_word_t     want;
        if (w.command == CMD_LOAD) begin
            tap_coeffs[w.tap_index] = w.value;
            n_loads++;
            return;
        end
        n_samples++;
        // out-of-range registers are clamped into their working range
        n_taps   = (tap_count_q == 0) ? 1 :
                   (tap_count_q > MAX_TAPS_DEF) ? MAX_TAPS_DEF : tap_count_q;
        n_stride = (stride_q == 0) ? 1 : (stride_q > MAX_STRIDE) ? MAX_STRIDE : stride_q;

        for (int k = MAX_TAPS_DEF - 1; k > 0; k--)
            row_samples[k] = row_samples[k-1];
        row_samples[0] = w.value;
        if (fill_count < n_taps)
            fill_count++;

        fired = 1'b0;
        want  = '0;
        if (fill_count >= n_taps) begin
            if (stride_phase == 0) begin
                fired       = 1'b1;
                want.result = window_value(n_taps);
                n_windows++;
            end
            stride_phase = (stride_phase + 1 >= n_stride) ? 0 : stride_phase + 1;
        end

        if (fired || w.last) begin
            want.has_value = fired;
            want.row_end   = w.last;
            want.status    = w.last && (fill_count < n_taps);
            if (want.status)
                n_short++;
            pending_outputs.push_back(want);
        end
        if (w.last)
            clear_row();
    endtask

    always @(posedge aclk) begin
        m_word_t want;
        if (!aresetn) begin
            tap_count_q = TAP_COUNT_RST;
            stride_q    = STRIDE_RST;
            bias_q      = '0;
            foreach (tap_coeffs[i]) tap_coeffs[i] = '0;
            clear_row();
            pending_outputs.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TAP_COUNT: tap_count_q = cfg_wdata[CNT_W-1:0];
                    CFG_STRIDE:    stride_q    = cfg_wdata[CNT_W-1:0];
                    CFG_BIAS:      bias_q      = cfg_wdata;
                    default: ;
                endcase
            end

            if (s_valid && s_ready)
                take_word(s_data);

            // compare each delivered word against the oldest expectation
            if (m_valid && m_ready) begin
                n_results++;
                if (pending_outputs.size() == 0) begin
                    $error("result word with nothing expected: %p", m_data);
                    errs++;
                end else begin
                    want = pending_outputs.pop_front();
                    if (m_data.result !== want.result) begin
                        $error("result: expected %0d, got %0d", want.result, m_data.result);
                        errs++;
                    end
                    if (m_data.has_value !== want.has_value) begin
                        $error("has_value: expected %0d, got %0d",
                               want.has_value, m_data.has_value);
                        errs++;
                    end
                    if (m_data.row_end !== want.row_end) begin
                        $error("row_end: expected %0d, got %0d", want.row_end, m_data.row_end);
                        errs++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        errs++;
                    end
                end
            end
        end

        err_count       <= errs;
        outstanding     <= pending_outputs.size();
        samples_seen    <= n_samples;
        loads_seen      <= n_loads;
        results_seen    <= n_results;
        windows_seen    <= n_windows;
        short_rows_seen <= n_short;
    end

endmodule

// ----- test/tb_strided_conv1d_bias_leaky_relu_top.sv -----
module tb_strided_conv1d_bias_leaky_relu_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scl_pkg::*;

    localparam int RANDOM_WORDS = 1150;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_RARE_STALL,
        RX_SLOW
    } rx_mode_e;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    s_word_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    m_word_t               m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  hold_go;

    int err_count;
    int outstanding;
    int samples_seen;
    int loads_seen;
    int results_seen;
    int windows_seen;
    int short_rows_seen;

    int words_sent    = 0;
    int burst_left    = 0;
    int settings_used = 0;
    int cycle_cnt     = 0;

    strided_conv1d_bias_leaky_relu_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    conv1d_result_monitor u_monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .err_count       (err_count),
        .outstanding     (outstanding),
        .samples_seen    (samples_seen),
        .loads_seen      (loads_seen),
        .results_seen    (results_seen),
        .windows_seen    (windows_seen),
        .short_rows_seen (short_rows_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off on request
    initial begin
        rx_mode_e mode;
        int       mode_left;
        bit       hold_done;
        mode      = RX_ALWAYS;
        mode_left = 0;
        hold_done = 1'b0;
        m_ready  <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_go === 1'b1 && !hold_done) begin
                hold_done = 1'b1;
                m_ready  <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (mode_left == 0) begin
                mode      = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                RX_ALWAYS:     m_ready <= 1'b1;
                RX_COIN:       m_ready <= 1'($urandom_range(0, 1));
                RX_RARE_STALL: m_ready <= ($urandom_range(0, 9) != 0);
                default:       m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Q8.8 value: extremes, full-range noise, or small magnitudes that avoid saturation
    function automatic logic [SAMPLE_BITS-1:0] rand_q88();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3, 4:    return 16'($urandom);
            default: return 16'($urandom_range(0, 1023) - 512);
        endcase
    endfunction

    // Offer one word; bursts of random length separated by random gaps
    task automatic send_word(input s_word_t w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] v, input logic last);
        s_word_t w;
        w.command   = CMD_SAMPLE;
        w.tap_index = TAP_IDX_W'($urandom);
        w.value     = v;
        w.last      = last;
        send_word(w);
    endtask

    task automatic send_load(input logic [TAP_IDX_W-1:0] idx,
                             input logic [SAMPLE_BITS-1:0] v, input logic last);
        s_word_t w;
        w.command   = CMD_LOAD;
        w.tap_index = idx;
        w.value     = v;
        w.last      = last;
        send_word(w);
    endtask

    // One row of random samples, with the odd tap load slipped in mid-row
    task automatic send_row(input int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0)
                send_load(TAP_IDX_W'($urandom), rand_q88(), 1'($urandom));
            send_sample(rand_q88(), i == len - 1);
        end
    endtask

    // Three register writes back to back; spare upper data bits are random
    task automatic write_config(input logic [CNT_W-1:0] tc, input logic [CNT_W-1:0] st,
                                input logic [SAMPLE_BITS-1:0] b);
        logic [CFG_DATA_W-1:0] pad;
        pad = CFG_DATA_W'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TAP_COUNT;
        cfg_wdata <= {pad[CFG_DATA_W-1:CNT_W], tc};
        @(posedge aclk);
        pad = CFG_DATA_W'($urandom);
        cfg_index <= CFG_STRIDE;
        cfg_wdata <= {pad[CFG_DATA_W-1:CNT_W], st};
        @(posedge aclk);
        cfg_index <= CFG_BIAS;
        cfg_wdata <= b;
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Stop sending and let every owed result out, then let the pipeline empty
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int               phase;
        int               rows;
        int               len;
        int               n_taps;
        int               n_stride;
        int               random_start;
        logic [CNT_W-1:0] tc;
        logic [CNT_W-1:0] st;
        logic [15:0]      b;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_TAP_COUNT;
        cfg_wdata <= '0;
        hold_go   <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: three taps, two at the extremes, so only loaded taps are ever used
        write_config(5'd3, 5'd1, 16'h0000);
        send_load(4'd0, 16'h7FFF, 1'b1);
        send_load(4'd1, 16'h8000, 1'b0);
        send_load(4'd2, 16'h0100, 1'b1);
        // rows shorter than the filter
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        // saturating windows every sample, tap reloaded mid-row
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_load(4'd2, 16'hFF00, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0100, 1'b0);
        send_sample(16'h8000, 1'b1);
        drain();
        // stride 3 with the most negative bias: last sample off the stride, then on it
        write_config(5'd3, 5'd3, 16'h8000);
        repeat (4) send_sample(rand_q88(), 1'b0);
        send_sample(16'h0040, 1'b1);
        repeat (5) send_sample(rand_q88(), 1'b0);
        send_sample(16'h7FFF, 1'b1);
        drain();

        // Random: fill the whole tap store first
        random_start = words_sent;
        for (int i = 0; i < MAX_TAPS_DEF; i++)
            send_load(TAP_IDX_W'(i), rand_q88(), 1'($urandom));
        drain();

        phase = 0;
        while (words_sent - random_start < RANDOM_WORDS) begin
            case (phase)
                0: begin tc = 5'd16; st = 5'd16; b = 16'h0000; end
                1: begin tc = 5'd1;  st = 5'd1;  b = 16'h7FFF; end
                2: begin tc = 5'd4;  st = 5'd1;  b = 16'h8000; end
                3: begin tc = 5'd0;  st = 5'd0;  b = 16'h0100; end
                4: begin tc = 5'd31; st = 5'd31; b = 16'hFF00; end
                5: begin tc = 5'd17; st = 5'd17; b = 16'h0005; end
                default: begin
                    tc = ($urandom_range(0, 4) == 0) ? CNT_W'($urandom_range(0, 31)) :
                                                       CNT_W'($urandom_range(1, 16));
                    st = ($urandom_range(0, 4) == 0) ? CNT_W'($urandom_range(0, 31)) :
                                                       CNT_W'($urandom_range(1, 6));
                    b  = rand_q88();
                end
            endcase
            write_config(tc, st, b);
            n_taps   = (tc == 0) ? 1 : (tc > MAX_TAPS_DEF) ? MAX_TAPS_DEF : tc;
            n_stride = (st == 0) ? 1 : (st > MAX_STRIDE) ? MAX_STRIDE : st;

            repeat ($urandom_range(0, 3))
                send_load(TAP_IDX_W'($urandom), rand_q88(), 1'($urandom));

            // one window per sample here, so a long receiver hold-off backs the block up
            if (phase == 2)
                hold_go <= 1'b1;

            rows = $urandom_range(3, 8);
            repeat (rows) begin
                if (words_sent - random_start >= RANDOM_WORDS)
                    break;
                if (n_taps > 1 && $urandom_range(0, 7) == 0)
                    len = $urandom_range(1, n_taps - 1);
                else
                    len = $urandom_range(n_taps, n_taps + 4 * n_stride);
                send_row(len);
            end
            drain();
            phase++;
        end

        drain();
        repeat (12) @(posedge aclk);
        if (outstanding != 0)
            $error("%0d expected result words never arrived", outstanding);

        $display("Covered %0d sample words and %0d tap loads over %0d register settings.",
                 samples_seen, loads_seen, settings_used);
        $display("Checked %0d result words: %0d with a window value, %0d short rows.",
                 results_seen, windows_seen, short_rows_seen);
        if (err_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/scl_pkg.sv
sv/strided_conv1d_bias_leaky_relu_top.sv
sv/scl_checker.sv
test/conv1d_result_monitor.sv
test/tb_strided_conv1d_bias_leaky_relu_top.sv
